// ----- hdl/assert_macros.svh -----
// Assertion macros used by the cache RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising edge outside reset.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Implication checked on every rising edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`endif

// ----- hdl/lru_wbc_pkg.sv -----
// Types and constants of the write-back LRU block cache.
package lru_wbc_pkg;
   localparam int GroupBits   = 6;
   localparam int MaxLines    = 8;
   localparam int StoreWords  = 4096;
   localparam int GroupWords  = 1 << GroupBits;
   localparam int IdxBits     = $clog2(StoreWords);
   localparam int GrpBits     = IdxBits - GroupBits;
   localparam int SlotBits    = (MaxLines > 1) ? $clog2(MaxLines) : 1;
   localparam int AgeBits     = SlotBits;
   localparam int LineAddrBits = SlotBits + GroupBits;
   localparam int CountBits   = 13;
   localparam int LimitBits   = 4;
   localparam int CsrIdxBits  = 1;

   localparam logic [CsrIdxBits-1:0] CsrElementCount = 1'd0;
   localparam logic [CsrIdxBits-1:0] CsrLinesInUse   = 1'd1;
   localparam logic OpRead  = 1'b0;
   localparam logic OpWrite = 1'b1;

   typedef enum logic [3:0] {
      ST_CLEAR, ST_IDLE, ST_LOOKUP, ST_EVICT_PICK, ST_WB_RD, ST_WB_WR,
      ST_FILL_RD, ST_FILL_WR, ST_ACCESS, ST_ACCESS_RD, ST_RESPOND
   } state_type;
endpackage

// ----- hdl/lru_write_back_block_cache.sv -----
// Top level of the write-back LRU block cache.
//  channel | direction | handshake             | payload
//  req     | in        | req_tvalid/req_tready | tdata: operation, element_index, write_value
//  rsp     | out       | rsp_tvalid/rsp_tready | tdata: read_value, hit, evicted_valid, ...
//  csr     | in        | csr_valid/csr_ready   | csr_index, csr_data
// One item at a time. A hit goes through lookup, the eviction check, the line access and
// the line read before its response is registered. Each eviction goes through the pick
// state; a dirty one first writes the group back (read and write over the group plus one
// extra word), and a fill runs likewise. An index error goes from lookup to the response.
// After reset a clearing pass zeroes the backing store word by word; no request is
// taken meanwhile. The response is held in an output register until transferred,
// and the next request may be taken while it waits.
`include "assert_macros.svh"
module lru_write_back_block_cache (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // operation[0], element_index[12:1], write_value[76:13], zero fill to 80
   input  logic [79:0]  req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // read_value[63:0], hit[64], evicted_valid[65], evicted_group[71:66],
   // wrote_back[72], index_error[73], zero fill to 80
   output logic [79:0]  rsp_tdata,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [lru_wbc_pkg::CsrIdxBits-1:0] csr_index,
   input  logic [15:0]  csr_data
);
   localparam int IB = lru_wbc_pkg::IdxBits;
   localparam int GB = lru_wbc_pkg::GrpBits;
   localparam int SB = lru_wbc_pkg::SlotBits;
   localparam int AB = lru_wbc_pkg::AgeBits;
   localparam int OB = lru_wbc_pkg::GroupBits;
   localparam int ML = lru_wbc_pkg::MaxLines;

   lru_wbc_pkg::state_type state_ff, state_in;

   logic [63:0] store_mem [lru_wbc_pkg::StoreWords];
   logic [63:0] line_mem  [ML * lru_wbc_pkg::GroupWords];
   logic [63:0] store_rd_ff, line_rd_ff;
   logic        store_we, line_we;
   logic [IB-1:0] store_wa, store_ra;
   logic [lru_wbc_pkg::LineAddrBits-1:0] line_wa, line_ra;
   logic [63:0] store_wd, line_wd;

   logic [lru_wbc_pkg::CountBits-1:0] count_ff;
   logic [lru_wbc_pkg::LimitBits-1:0] limit_ff;
   logic [ML-1:0] valid_ff, dirty_ff;
   logic [GB-1:0] group_ff [ML];
   logic [AB-1:0] age_ff [ML];

   logic          op_ff;
   logic [IB-1:0] idx_ff;
   logic [63:0]   wv_ff;
   logic          hit_ff, ev_ff, wb_ff;
   logic [GB-1:0] evgrp_ff;
   logic [SB-1:0] slot_ff, victim_ff;
   logic [OB:0]   word_ff;
   logic [IB:0]   clr_ff;

   logic          rsp_valid_ff;
   logic [79:0]   rsp_data_ff;

   // Effective count and limit.
   logic [IB:0]   count_eff;
   logic [SB:0]   limit_eff;
   logic [SB:0]   n_valid;
   logic          hit_c;
   logic [SB-1:0] hit_slot, free_slot, victim_c;
   logic          victim_found;
   logic          idx_err;
   logic [GB-1:0] grp;
   logic [IB:0]   wb_addr;

   assign grp = idx_ff[IB-1:OB];
   assign count_eff = (count_ff > lru_wbc_pkg::CountBits'(lru_wbc_pkg::StoreWords))
                      ? (IB+1)'(lru_wbc_pkg::StoreWords) : count_ff[IB:0];
   assign limit_eff = (limit_ff == '0) ? (SB+1)'(1)
                      : (limit_ff > lru_wbc_pkg::LimitBits'(ML)) ? (SB+1)'(ML)
                      : (SB+1)'(limit_ff);
   assign idx_err = {1'b0, idx_ff} >= count_eff;

   always_comb begin
      n_valid = '0;
      hit_c = 1'b0;
      hit_slot = '0;
      free_slot = '0;
      victim_c = '0;
      victim_found = 1'b0;
      for (int j = ML - 1; j >= 0; j--) begin
         if (valid_ff[j]) n_valid = n_valid + (SB+1)'(1);
         if (valid_ff[j] && group_ff[j] == grp) begin
            hit_c = 1'b1;
            hit_slot = SB'(j);
         end
         if (!valid_ff[j]) free_slot = SB'(j);
      end
      for (int j = 0; j < ML; j++) begin
         if (valid_ff[j] && !(hit_ff && SB'(j) == slot_ff) &&
             (!victim_found || age_ff[j] > age_ff[victim_c])) begin
            victim_c = SB'(j);
            victim_found = 1'b1;
         end
      end
   end

   assign wb_addr = {1'b0, group_ff[victim_ff], word_ff[OB-1:0]};

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         lru_wbc_pkg::ST_CLEAR:
            if (clr_ff == (IB+1)'(lru_wbc_pkg::StoreWords - 1)) state_in = lru_wbc_pkg::ST_IDLE;
         lru_wbc_pkg::ST_IDLE:
            if (req_tvalid) state_in = lru_wbc_pkg::ST_LOOKUP;
         lru_wbc_pkg::ST_LOOKUP:
            if (idx_err) state_in = lru_wbc_pkg::ST_RESPOND;
            else state_in = lru_wbc_pkg::ST_EVICT_PICK;
         lru_wbc_pkg::ST_EVICT_PICK:
            if (hit_ff ? (n_valid > limit_eff) : (n_valid >= limit_eff)) begin
               if (dirty_ff[victim_c]) state_in = lru_wbc_pkg::ST_WB_RD;
            end else if (hit_ff) state_in = lru_wbc_pkg::ST_ACCESS;
            else state_in = lru_wbc_pkg::ST_FILL_RD;
         lru_wbc_pkg::ST_WB_RD:
            state_in = lru_wbc_pkg::ST_WB_WR;
         lru_wbc_pkg::ST_WB_WR:
            if (word_ff[OB]) state_in = lru_wbc_pkg::ST_EVICT_PICK;
            else state_in = lru_wbc_pkg::ST_WB_RD;
         lru_wbc_pkg::ST_FILL_RD:
            state_in = lru_wbc_pkg::ST_FILL_WR;
         lru_wbc_pkg::ST_FILL_WR:
            if (word_ff[OB]) state_in = lru_wbc_pkg::ST_ACCESS;
            else state_in = lru_wbc_pkg::ST_FILL_RD;
         lru_wbc_pkg::ST_ACCESS:
            state_in = lru_wbc_pkg::ST_ACCESS_RD;
         lru_wbc_pkg::ST_ACCESS_RD:
            state_in = lru_wbc_pkg::ST_RESPOND;
         lru_wbc_pkg::ST_RESPOND:
            if (!rsp_valid_ff || rsp_tready) state_in = lru_wbc_pkg::ST_IDLE;
         default:
            state_in = lru_wbc_pkg::ST_IDLE;
      endcase
   end

   // Memory ports and handshakes.
   always_comb begin
      req_tready = (state_ff == lru_wbc_pkg::ST_IDLE);
      csr_ready  = 1'b1;
      store_we = 1'b0;
      store_wa = idx_ff;
      store_wd = line_rd_ff;
      store_ra = {grp, word_ff[OB-1:0]};
      line_we  = 1'b0;
      line_wa  = {slot_ff, word_ff[OB-1:0]};
      line_wd  = ({1'b0, grp, word_ff[OB-1:0]} < count_eff) ? store_rd_ff : 64'd0;
      line_ra  = {slot_ff, idx_ff[OB-1:0]};
      case (state_ff)
         lru_wbc_pkg::ST_CLEAR: begin
            store_we = 1'b1;
            store_wa = clr_ff[IB-1:0];
            store_wd = 64'd0;
         end
         lru_wbc_pkg::ST_WB_RD:
            line_ra = {victim_ff, word_ff[OB-1:0]};
         lru_wbc_pkg::ST_WB_WR: begin
            store_we = wb_addr < count_eff;
            store_wa = wb_addr[IB-1:0];
         end
         lru_wbc_pkg::ST_FILL_WR:
            line_we = 1'b1;
         lru_wbc_pkg::ST_ACCESS: begin
            line_we = (op_ff == lru_wbc_pkg::OpWrite);
            line_wa = {slot_ff, idx_ff[OB-1:0]};
            line_wd = wv_ff;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (store_we) store_mem[store_wa] <= store_wd;
      store_rd_ff <= store_mem[store_ra];
      if (line_we) line_mem[line_wa] <= line_wd;
      line_rd_ff <= line_mem[line_ra];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lru_wbc_pkg::ST_CLEAR;
         clr_ff <= '0;
         count_ff <= lru_wbc_pkg::CountBits'(4096);
         limit_ff <= lru_wbc_pkg::LimitBits'(8);
         valid_ff <= '0;
         dirty_ff <= '0;
         rsp_valid_ff <= 1'b0;
         for (int j = 0; j < ML; j++) begin
            group_ff[j] <= '0;
            age_ff[j] <= '0;
         end
      end else begin
         state_ff <= state_in;
         if (csr_valid) begin
            case (csr_index)
               lru_wbc_pkg::CsrElementCount: count_ff <= csr_data[lru_wbc_pkg::CountBits-1:0];
               lru_wbc_pkg::CsrLinesInUse:   limit_ff <= csr_data[lru_wbc_pkg::LimitBits-1:0];
               default: ;
            endcase
         end
         // Drop the transferred response unless a new one takes its place.
         if (rsp_valid_ff && rsp_tready && state_ff != lru_wbc_pkg::ST_RESPOND)
            rsp_valid_ff <= 1'b0;
         case (state_ff)
            lru_wbc_pkg::ST_CLEAR: clr_ff <= clr_ff + (IB+1)'(1);
            lru_wbc_pkg::ST_IDLE: begin
               op_ff  <= req_tdata[0];
               idx_ff <= req_tdata[IB:1];
               wv_ff  <= req_tdata[IB+64:IB+1];
               ev_ff <= 1'b0;
               wb_ff <= 1'b0;
               evgrp_ff <= '0;
            end
            lru_wbc_pkg::ST_LOOKUP: begin
               hit_ff <= hit_c;
               slot_ff <= hit_slot;
               if (!idx_err && hit_c) begin
                  // promote the hit line to most recent
                  for (int j = 0; j < ML; j++)
                     if (valid_ff[j] && age_ff[j] < age_ff[hit_slot])
                        age_ff[j] <= age_ff[j] + AB'(1);
                  age_ff[hit_slot] <= '0;
               end
            end
            lru_wbc_pkg::ST_EVICT_PICK: begin
               word_ff <= '0;
               if (hit_ff ? (n_valid > limit_eff) : (n_valid >= limit_eff)) begin
                  victim_ff <= victim_c;
                  ev_ff <= 1'b1;
                  evgrp_ff <= group_ff[victim_c];
                  if (dirty_ff[victim_c]) wb_ff <= 1'b1;
                  else valid_ff[victim_c] <= 1'b0;
               end else if (!hit_ff) begin
                  slot_ff <= free_slot;
               end
            end
            lru_wbc_pkg::ST_WB_WR: begin
               word_ff <= word_ff + (OB+1)'(1);
               if (word_ff[OB]) begin
                  valid_ff[victim_ff] <= 1'b0;
                  dirty_ff[victim_ff] <= 1'b0;
               end
            end
            lru_wbc_pkg::ST_FILL_WR: begin
               word_ff <= word_ff + (OB+1)'(1);
               if (word_ff[OB]) begin
                  for (int j = 0; j < ML; j++)
                     if (valid_ff[j]) age_ff[j] <= age_ff[j] + AB'(1);
                  age_ff[slot_ff] <= '0;
                  group_ff[slot_ff] <= grp;
                  valid_ff[slot_ff] <= 1'b1;
                  dirty_ff[slot_ff] <= 1'b0;
               end
            end
            lru_wbc_pkg::ST_ACCESS:
               if (op_ff == lru_wbc_pkg::OpWrite) dirty_ff[slot_ff] <= 1'b1;
            lru_wbc_pkg::ST_RESPOND:
               if (!rsp_valid_ff || rsp_tready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_data_ff <= idx_err ? {6'd0, 1'b1, 73'd0}
                     : {6'd0, 1'b0, wb_ff, evgrp_ff, ev_ff, hit_ff, line_rd_ff};
               end
            default: ;
         endcase
      end
   end

   // The fill and write-back sweeps run one word past the group end; keep word_ff in range.
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   `ASSERT_CLK(a_req_idle, clock, reset,
      (req_tvalid && req_tready) |=> (state_ff == lru_wbc_pkg::ST_LOOKUP),
      "accepted request did not start a lookup")
   `ASSERT_CLK(a_limit, clock, reset,
      (state_ff == lru_wbc_pkg::ST_RESPOND) |-> (n_valid <= (lru_wbc_pkg::SlotBits+1)'(ML)),
      "more valid lines than the cache holds")
   `ASSERT_ALWAYS(a_clear, clock,
      (state_ff == lru_wbc_pkg::ST_CLEAR) |-> !req_tready,
      "request taken during store clearing")
endmodule
